// ===== src/bffu_pkg.sv =====
// shared types, constants and rounding function of the bilinear flow field upscaler
package bffu_pkg;

  localparam int MAX_IN_WIDTH  = 256;
  localparam int MAX_IN_HEIGHT = 256;
  localparam int CHANNELS      = 3;

  localparam int SAMPLE_W = 16;
  localparam int NUM_CH   = 3;
  localparam int DATA_W   = CHANNELS * SAMPLE_W;
  localparam int COORD_W  = 12;
  localparam int STEP_W   = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIM_CFG_W  = 9;

  localparam int CLOG_W = $clog2(MAX_IN_WIDTH + 1);
  localparam int CLOG_H = $clog2(MAX_IN_HEIGHT + 1);
  localparam int SIZE_A = (CLOG_W > DIM_CFG_W) ? CLOG_W : DIM_CFG_W;
  localparam int SIZE_W = (CLOG_H > SIZE_A) ? CLOG_H : SIZE_A;

  localparam int FRAC_W = 16;
  localparam int POS_W  = COORD_W + STEP_W;
  localparam int KX_W   = POS_W - FRAC_W;
  localparam int PX_W   = KX_W + 1;
  localparam int WGT1_W = FRAC_W + 1;
  localparam int WGT_W  = 2 * FRAC_W + 1;
  localparam int PROD_W = WGT_W + 1 + SAMPLE_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int Q_W    = ACC_W - 2 * FRAC_W;

  localparam int HALF_W_CB = $clog2((MAX_IN_WIDTH + 1) / 2);
  localparam int HALF_H_RB = $clog2((MAX_IN_HEIGHT + 1) / 2);
  localparam int BANK_CB   = (HALF_W_CB > 0) ? HALF_W_CB : 1;
  localparam int BANK_RB   = (HALF_H_RB > 0) ? HALF_H_RB : 1;
  localparam int BANK_AW   = BANK_CB + BANK_RB;
  localparam int BANK_DEPTH = 2 ** BANK_AW;
  localparam int NUM_BANKS = 4;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_CONF  = 3'd4;

  typedef struct packed {
    logic                       req_type;
    logic [COORD_W-1:0]         coord_x;
    logic [COORD_W-1:0]         coord_y;
    logic signed [SAMPLE_W-1:0] flow_u;
    logic signed [SAMPLE_W-1:0] flow_v;
    logic signed [SAMPLE_W-1:0] conf_in;
  } req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] u_out;
    logic signed [SAMPLE_W-1:0] v_out;
    logic signed [SAMPLE_W-1:0] conf_out;
  } result_t;

  // neighbour control that travels beside the bank read data
  typedef struct packed {
    logic                             q;
    logic                             conf_on;
    logic [NUM_BANKS-1:0]             vld;
    logic [NUM_BANKS-1:0][WGT_W-1:0]  wgt;
  } blend_ctl_t;

  // round a Q.38 sum to Q9.6, halves up, then saturate
  function automatic logic signed [SAMPLE_W-1:0] round_sat(
    input logic signed [ACC_W-1:0] acc
  );
    logic signed [ACC_W-1:0] t;
    logic signed [Q_W-1:0]   q;
    logic signed [SAMPLE_W-1:0] r;
    t = acc + $signed(ACC_W'(1) << (2 * FRAC_W - 1));
    q = t[ACC_W-1:2*FRAC_W];
    if (q > Q_W'(32767)) begin
      r = 16'sh7fff;
    end else if (q < Q_W'(-32768)) begin
      r = 16'sh8000;
    end else begin
      r = q[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/bffu_ram.sv =====
// generic single-write, single-read ram with registered read data
module bffu_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bffu_map.sv =====
// query front end: source position, neighbour bank addresses and 2d weights
module bffu_map
  import bffu_pkg::*;
(
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  q_valid,
  input  logic [COORD_W-1:0]                    coord_x,
  input  logic [COORD_W-1:0]                    coord_y,
  input  logic [STEP_W-1:0]                     step_x,
  input  logic [STEP_W-1:0]                     step_y,
  input  logic [SIZE_W-1:0]                     wdt,
  input  logic [SIZE_W-1:0]                     hgt,
  input  logic                                  conf_on,
  output logic [NUM_BANKS-1:0][BANK_AW-1:0]     rd_addr,
  output blend_ctl_t                            ctl
);

  logic             q1;
  logic             conf1;
  logic [POS_W-1:0] rx;
  logic [POS_W-1:0] ry;

  logic [KX_W-1:0]   kx;
  logic [KX_W-1:0]   ky;
  logic [FRAC_W-1:0] fx;
  logic [FRAC_W-1:0] fy;
  logic [NUM_BANKS-1:0]             vld_next;
  logic [NUM_BANKS-1:0][WGT_W-1:0]  wgt_next;

  // source position, one multiplier per axis
  always_ff @(posedge clk) begin
    if (rst) begin
      q1 <= 1'b0;
    end else begin
      q1 <= q_valid;
    end
    conf1 <= conf_on;
    rx    <= POS_W'(coord_x) * POS_W'(step_x);
    ry    <= POS_W'(coord_y) * POS_W'(step_y);
  end

  assign kx = rx[POS_W-1:FRAC_W];
  assign ky = ry[POS_W-1:FRAC_W];
  assign fx = rx[FRAC_W-1:0];
  assign fy = ry[FRAC_W-1:0];

  // bank b holds row parity b[1] and column parity b[0]
  always_comb begin
    logic              dx;
    logic              dy;
    logic [PX_W-1:0]   px;
    logic [PX_W-1:0]   py;
    logic [WGT1_W-1:0] wx;
    logic [WGT1_W-1:0] wy;
    logic [2*WGT1_W-1:0] w2;
    for (int b = 0; b < NUM_BANKS; b++) begin
      dx = kx[0] ^ b[0];
      dy = ky[0] ^ b[1];
      px = {1'b0, kx} + PX_W'(dx);
      py = {1'b0, ky} + PX_W'(dy);
      wx = dx ? {1'b0, fx} : (WGT1_W'(1) << FRAC_W) - {1'b0, fx};
      wy = dy ? {1'b0, fy} : (WGT1_W'(1) << FRAC_W) - {1'b0, fy};
      w2 = (2*WGT1_W)'(wx) * (2*WGT1_W)'(wy);
      wgt_next[b] = w2[WGT_W-1:0];
      vld_next[b] = (px < PX_W'(wdt)) && (py < PX_W'(hgt));
      rd_addr[b]  = {py[BANK_RB:1], px[BANK_CB:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.q <= 1'b0;
    end else begin
      ctl.q <= q1;
    end
    ctl.conf_on <= conf1;
    ctl.vld     <= vld_next;
    ctl.wgt     <= wgt_next;
  end

endmodule

// ===== src/bffu_blend.sv =====
// weighted sum of the four neighbours, rounding and saturation
module bffu_blend
  import bffu_pkg::*;
(
  input  logic                               clk,
  input  logic                               rst,
  input  blend_ctl_t                         ctl,
  input  logic [NUM_BANKS-1:0][DATA_W-1:0]   rd_data,
  output logic                               done,
  output result_t                            result
);

  logic q3;
  logic q4;
  logic signed [PROD_W-1:0] prod     [NUM_CH][NUM_BANKS];
  logic signed [PROD_W-1:0] prod_next[NUM_CH][NUM_BANKS];
  logic signed [ACC_W-1:0]  acc      [NUM_CH];
  logic signed [ACC_W-1:0]  acc_next [NUM_CH];

  // skipped neighbours and a disabled channel contribute zero
  always_comb begin
    logic [NUM_CH*SAMPLE_W-1:0] ext;
    logic signed [SAMPLE_W-1:0] d;
    logic signed [WGT_W:0]      ws;
    logic                       en;
    for (int b = 0; b < NUM_BANKS; b++) begin
      ext = (NUM_CH*SAMPLE_W)'(rd_data[b]);
      ws  = $signed({1'b0, ctl.wgt[b]});
      for (int ch = 0; ch < NUM_CH; ch++) begin
        d  = $signed(ext[ch*SAMPLE_W +: SAMPLE_W]);
        en = ctl.vld[b] && (ch < CHANNELS) && ((ch < 2) || ctl.conf_on);
        // full product width: weight up to 2^32 times a 16-bit sample
        prod_next[ch][b] = en ? (PROD_W'(ws) * PROD_W'(d)) : '0;
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      acc_next[ch] = ACC_W'(prod[ch][0]) + ACC_W'(prod[ch][1])
                   + ACC_W'(prod[ch][2]) + ACC_W'(prod[ch][3]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q3   <= 1'b0;
      q4   <= 1'b0;
      done <= 1'b0;
    end else begin
      q3   <= ctl.q;
      q4   <= q3;
      done <= q4;
    end
    prod            <= prod_next;
    acc             <= acc_next;
    result.u_out    <= round_sat(acc[0]);
    result.v_out    <= round_sat(acc[1]);
    result.conf_out <= round_sat(acc[2]);
  end

endmodule

// ===== src/bilinear_flow_field_upscaler.sv =====
// top level of the bilinear flow field upscaler: config, input word, sample banks
//
// usage
// - input words enter on start; a word is taken at a clock edge with start high
//   and busy low. busy is low at all times after reset, so one word per cycle
// - a load word (req_type 0) writes one sample; loads outside the field size
//   are dropped. a load gives no result
// - a query word (req_type 1) gives one result word on result, marked by a
//   one-cycle done strobe
// - throughput is one word per cycle, loads and queries mixed freely: the
//   sample store is split into four banks by row and column parity, so the
//   four neighbours of a query are read in the same cycle, one per bank
// - results cannot be held off; they appear in the order the queries came
// - config registers are written on the cfg channel (cfg_ready is always high);
//   write them only while no word is in flight, the block does not enforce it
// - reset clears the pipeline and loads the register defaults; the sample
//   store is not cleared, and a query may only touch samples loaded before it
module bilinear_flow_field_upscaler
  import bffu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  req_t                  in_word,
  output logic                  done,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // config registers
  logic [DIM_CFG_W-1:0] in_width;
  logic [DIM_CFG_W-1:0] in_height;
  logic [STEP_W-1:0]    step_x;
  logic [STEP_W-1:0]    step_y;
  logic                 has_confidence;

  // effective field size and confidence mode
  logic [SIZE_W-1:0] wdt;
  logic [SIZE_W-1:0] hgt;
  logic              conf_on;

  // registered input word
  logic s0_valid;
  req_t s0;

  logic                              accept;
  logic                              load_ok;
  logic [BANK_AW-1:0]                wr_addr;
  logic [NUM_BANKS-1:0]              wr_en;
  logic [NUM_BANKS-1:0][BANK_AW-1:0] rd_addr;
  logic [NUM_BANKS-1:0][DATA_W-1:0]  rd_data;
  blend_ctl_t                        ctl;
  logic [3*SAMPLE_W-1:0]             sample;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_width       <= DIM_CFG_W'(256);
      in_height      <= DIM_CFG_W'(256);
      step_x         <= STEP_W'(65536);
      step_y         <= STEP_W'(65536);
      has_confidence <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_IN_WIDTH:  in_width       <= cfg_data[DIM_CFG_W-1:0];
        CFG_IN_HEIGHT: in_height      <= cfg_data[DIM_CFG_W-1:0];
        CFG_STEP_X:    step_x         <= cfg_data[STEP_W-1:0];
        CFG_STEP_Y:    step_y         <= cfg_data[STEP_W-1:0];
        CFG_HAS_CONF:  has_confidence <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // zero size acts as one, oversize clamps to the store dimension
  always_comb begin
    if (in_width == '0) begin
      wdt = SIZE_W'(1);
    end else if (SIZE_W'(in_width) > SIZE_W'(MAX_IN_WIDTH)) begin
      wdt = SIZE_W'(MAX_IN_WIDTH);
    end else begin
      wdt = SIZE_W'(in_width);
    end
    if (in_height == '0) begin
      hgt = SIZE_W'(1);
    end else if (SIZE_W'(in_height) > SIZE_W'(MAX_IN_HEIGHT)) begin
      hgt = SIZE_W'(MAX_IN_HEIGHT);
    end else begin
      hgt = SIZE_W'(in_height);
    end
  end

  assign conf_on = has_confidence && (CHANNELS >= 3);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else begin
      s0_valid <= accept;
    end
    s0 <= in_word;
  end

  // loads write in the cycle after acceptance; a query reads its banks after
  // its source position register, so an earlier load is always in the store,
  // and a later load lands no earlier than the read edge, which reads old data
  assign load_ok = s0_valid && (s0.req_type == REQ_LOAD)
                && (s0.coord_x < COORD_W'(wdt)) && (s0.coord_y < COORD_W'(hgt));
  assign wr_addr = {s0.coord_y[BANK_RB:1], s0.coord_x[BANK_CB:1]};
  assign sample  = {s0.conf_in, s0.flow_v, s0.flow_u};

  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      wr_en[b] = load_ok && ({s0.coord_y[0], s0.coord_x[0]} == 2'(b));
    end
  end

  bffu_map u_map (
    .clk     (clk),
    .rst     (rst),
    .q_valid (s0_valid && (s0.req_type == REQ_QUERY)),
    .coord_x (s0.coord_x),
    .coord_y (s0.coord_y),
    .step_x  (step_x),
    .step_y  (step_y),
    .wdt     (wdt),
    .hgt     (hgt),
    .conf_on (conf_on),
    .rd_addr (rd_addr),
    .ctl     (ctl)
  );

  // four parity banks of the sample store
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    bffu_ram #(
      .WIDTH (DATA_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (wr_en[b]),
      .waddr (wr_addr),
      .wdata (sample[DATA_W-1:0]),
      .raddr (rd_addr[b]),
      .rdata (rd_data[b])
    );
  end

  bffu_blend u_blend (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .rd_data (rd_data),
    .done    (done),
    .result  (result)
  );

  // every accepted query gives a done strobe for its result word
  assert property (@(posedge clk) disable iff (rst)
    (accept && in_word.req_type == REQ_QUERY) |-> ##6 done)
    else $error("query without result word");

  // every result word traces back to a query
  assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept && in_word.req_type == REQ_QUERY, 6))
    else $error("result word without query");

  // at most one bank is written per cycle, and only for a load
  assert property (@(posedge clk) disable iff (rst)
    (wr_en != '0) |-> ($onehot(wr_en) && $past(accept && in_word.req_type == REQ_LOAD)))
    else $error("bad bank write");

  // confidence stays zero while the mode is off
  assert property (@(posedge clk) disable iff (rst)
    (done && !has_confidence) |-> (result.conf_out == '0))
    else $error("confidence leaked");

endmodule

// ===== sim/bilinear_flow_field_upscaler_tb.sv =====
// self-checking testbench of the bilinear flow field upscaler
module bilinear_flow_field_upscaler_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bffu_pkg::*;

  localparam int STORE_DEPTH  = MAX_IN_WIDTH * MAX_IN_HEIGHT;
  localparam int QUIET_LIMIT  = 1000;  // cycles with no word, result or register write
  localparam int DRAIN_CYCLES = 8;     // loads give no result
  localparam int PHASE_WORDS  = 150;
  localparam int MAX_COORD    = 4095;
  localparam int MAX_SHOWN    = 100;   // mismatch lines printed before going quiet
  // first register index past the defined list, writes there are dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd5;

  // predicts the blended flow of every query and checks the result words
  class flow_scoreboard;
    logic signed [SAMPLE_W-1:0] smp_u [STORE_DEPTH];
    logic signed [SAMPLE_W-1:0] smp_v [STORE_DEPTH];
    logic signed [SAMPLE_W-1:0] smp_c [STORE_DEPTH];
    logic [DIM_CFG_W-1:0] reg_w;
    logic [DIM_CFG_W-1:0] reg_h;
    logic [STEP_W-1:0]    reg_sx;
    logic [STEP_W-1:0]    reg_sy;
    logic                 reg_conf;
    result_t              blend_q[$];
    int                   fail_cnt;

    function new();
      reg_w    = 9'd256;
      reg_h    = 9'd256;
      reg_sx   = 24'h010000;
      reg_sy   = 24'h010000;
      reg_conf = 1'b0;
      fail_cnt = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        CFG_IN_WIDTH:  reg_w = d[DIM_CFG_W-1:0];
        CFG_IN_HEIGHT: reg_h = d[DIM_CFG_W-1:0];
        CFG_STEP_X:    reg_sx = d[STEP_W-1:0];
        CFG_STEP_Y:    reg_sy = d[STEP_W-1:0];
        CFG_HAS_CONF:  reg_conf = d[0];
        default: ;
      endcase
    endfunction

    // zero size acts as one, oversize acts as the maximum
    function int unsigned clamp_dim(logic [DIM_CFG_W-1:0] v, int unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
    endfunction

    function int unsigned field_w();
      return clamp_dim(reg_w, MAX_IN_WIDTH);
    endfunction

    function int unsigned field_h();
      return clamp_dim(reg_h, MAX_IN_HEIGHT);
    endfunction

    // Q.38 sum to Q9.6, halves up, saturated
    function logic signed [SAMPLE_W-1:0] round_q96(longint acc);
      longint q;
      q = (acc + (longint'(1) <<< 31)) >>> 32;
      if (q > 32767) return 16'sh7fff;
      if (q < -32768) return 16'sh8000;
      return SAMPLE_W'(q);
    endfunction

    function int pending();
      return blend_q.size();
    endfunction

    function void note_word(req_t w);
      int unsigned wdt;
      int unsigned hgt;
      int unsigned a;
      logic [POS_W-1:0] rx;
      logic [POS_W-1:0] ry;
      longint kx;
      longint ky;
      longint px;
      longint py;
      longint wgt;
      longint wx [2];
      longint wy [2];
      longint su;
      longint sv;
      longint sc;
      result_t r;
      wdt = field_w();
      hgt = field_h();
      if (w.req_type == REQ_LOAD) begin
        // confidence is stored even while the channel is off
        if (w.coord_x < wdt && w.coord_y < hgt) begin
          a = w.coord_y * MAX_IN_WIDTH + w.coord_x;
          smp_u[a] = w.flow_u;
          smp_v[a] = w.flow_v;
          smp_c[a] = w.conf_in;
        end
        return;
      end
      rx = POS_W'(w.coord_x) * POS_W'(reg_sx);
      ry = POS_W'(w.coord_y) * POS_W'(reg_sy);
      kx = longint'(rx >> FRAC_W);
      ky = longint'(ry >> FRAC_W);
      wx[1] = longint'(rx[FRAC_W-1:0]);
      wx[0] = 65536 - wx[1];
      wy[1] = longint'(ry[FRAC_W-1:0]);
      wy[0] = 65536 - wy[1];
      su = 0;
      sv = 0;
      sc = 0;
      for (int dy = 0; dy < 2; dy++) begin
        for (int dx = 0; dx < 2; dx++) begin
          py = ky + dy;
          px = kx + dx;
          // neighbours past the edge drop out with their weight
          if (py >= longint'(hgt) || px >= longint'(wdt)) continue;
          a = int'(py) * MAX_IN_WIDTH + int'(px);
          wgt = wx[dx] * wy[dy];
          su += wgt * longint'(smp_u[a]);
          sv += wgt * longint'(smp_v[a]);
          sc += wgt * longint'(smp_c[a]);
        end
      end
      r.u_out    = round_q96(su);
      r.v_out    = round_q96(sv);
      r.conf_out = (reg_conf && CHANNELS >= 3) ? round_q96(sc) : '0;
      blend_q.push_back(r);
    endfunction

    task report_mismatch(string what);
      fail_cnt++;
      if (fail_cnt <= MAX_SHOWN) $display("%0t ns mismatch: %s", $time, what);
    endtask

    task check_result(result_t got);
      result_t want;
      if (blend_q.size() == 0) begin
        report_mismatch($sformatf("result word with no query waiting: u=%0d v=%0d c=%0d",
                                  got.u_out, got.v_out, got.conf_out));
        return;
      end
      want = blend_q.pop_front();
      if (got.u_out !== want.u_out)
        report_mismatch($sformatf("u_out %0d, expected %0d", got.u_out, want.u_out));
      if (got.v_out !== want.v_out)
        report_mismatch($sformatf("v_out %0d, expected %0d", got.v_out, want.v_out));
      if (got.conf_out !== want.conf_out)
        report_mismatch($sformatf("conf_out %0d, expected %0d", got.conf_out, want.conf_out));
    endtask
  endclass

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  req_t                  in_word = '0;
  logic                  done;
  result_t               result;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  flow_scoreboard sb = new();

  // samples the stimulus has loaded so far, so no query touches an empty entry
  bit          loaded [STORE_DEPTH];
  int unsigned word_cnt = 0;
  int unsigned idle_pct = 0;
  int unsigned quiet_cycles = 0;

  bilinear_flow_field_upscaler dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // one process sees every accepted word and result, results checked first
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(result);
      if (start && !busy) sb.note_word(in_word);
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("bilinear_flow_field_upscaler test failed");
        $finish;
      end
    end
  end

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return -16'sd1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic req_t make_word(logic kind, int unsigned x, int unsigned y);
    req_t w;
    w.req_type = kind;
    w.coord_x  = COORD_W'(x);
    w.coord_y  = COORD_W'(y);
    w.flow_u   = rand_sample();
    w.flow_v   = rand_sample();
    w.conf_in  = rand_sample();
    return w;
  endfunction

  // highest output coordinate whose source position does not pass size + 1, capped at MAX_COORD
  function automatic int unsigned axis_reach(int unsigned size, logic [STEP_W-1:0] step);
    longint span;
    if (step == 0) return MAX_COORD;
    span = (longint'(size) + 1) * 65536 / longint'(step);
    return (span > MAX_COORD) ? MAX_COORD : int'(span);
  endfunction

  // random sender gaps: start is dropped while draws fall under idle_pct
  task automatic pace();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_word(req_t w);
    pace();
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    if (w.req_type == REQ_QUERY) begin
      word_cnt++;
    end else if (w.coord_x < sb.field_w() && w.coord_y < sb.field_h()) begin
      loaded[w.coord_y * MAX_IN_WIDTH + w.coord_x] = 1'b1;
      word_cnt++;
    end
  endtask

  task automatic load_sample(int unsigned x, int unsigned y,
                             logic signed [SAMPLE_W-1:0] u, logic signed [SAMPLE_W-1:0] v,
                             logic signed [SAMPLE_W-1:0] c);
    req_t w;
    w = make_word(REQ_LOAD, x, y);
    w.flow_u  = u;
    w.flow_v  = v;
    w.conf_in = c;
    send_word(w);
  endtask

  // loads any empty neighbour inside the field first, then sends the query
  task automatic query_at(int unsigned x, int unsigned y);
    logic [POS_W-1:0] rx;
    logic [POS_W-1:0] ry;
    int unsigned kx;
    int unsigned ky;
    int unsigned px;
    int unsigned py;
    rx = POS_W'(x) * POS_W'(sb.reg_sx);
    ry = POS_W'(y) * POS_W'(sb.reg_sy);
    kx = int'(rx >> FRAC_W);
    ky = int'(ry >> FRAC_W);
    for (int dy = 0; dy < 2; dy++) begin
      for (int dx = 0; dx < 2; dx++) begin
        px = kx + dx;
        py = ky + dy;
        if (px < sb.field_w() && py < sb.field_h() && !loaded[py * MAX_IN_WIDTH + px])
          send_word(make_word(REQ_LOAD, px, py));
      end
    end
    send_word(make_word(REQ_QUERY, x, y));
  endtask

  task automatic hold_for_results();
    start <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // leaves cfg_valid high, the caller lowers it after the last write
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
  endtask

  // registers change only with the pipeline empty; unused upper data bits are random
  task automatic set_field(int unsigned w, int unsigned h, logic [STEP_W-1:0] sx,
                           logic [STEP_W-1:0] sy, logic conf);
    hold_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_reg(CFG_IN_WIDTH, {15'($urandom), DIM_CFG_W'(w)});
    write_reg(CFG_IN_HEIGHT, {15'($urandom), DIM_CFG_W'(h)});
    write_reg(CFG_STEP_X, sx);
    write_reg(CFG_STEP_Y, sy);
    write_reg(CFG_HAS_CONF, {23'($urandom), conf});
    write_reg(CFG_SPARE + CFG_IDX_W'($urandom_range(2)), CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // corners, data extremes, ignored loads and edge weight loss
  task automatic directed_words();
    load_sample(0, 0, 16'sh7fff, 16'sh8000, 16'sh7fff);
    load_sample(1, 0, 16'sh8000, 16'sh7fff, 16'sh8000);
    load_sample(0, 1, -16'sd1, 16'sh0000, 16'sd1);
    load_sample(1, 1, 16'sh0000, -16'sd1, 16'sh8000);
    load_sample(7, 5, 16'sh7fff, 16'sh7fff, 16'sh7fff);
    load_sample(MAX_COORD, MAX_COORD, 16'sh7fff, 16'sh8000, 16'sh7fff);
    load_sample(8, 0, 16'sh1234, 16'sh4321, 16'sh0f0f);
    load_sample(0, 6, 16'sh8000, 16'sh8000, 16'sh8000);
    query_at(0, 0);
    query_at(1, 0);
    query_at(1, 1);
    query_at(15, 10);   // right neighbour past the edge
    query_at(14, 16);   // bottom neighbours past the edge
    query_at(15, 17);   // only one neighbour left
    query_at(MAX_COORD, MAX_COORD);
    query_at(MAX_COORD, 0);
    query_at(0, MAX_COORD);
    hold_for_results();
  endtask

  task automatic random_words(int unsigned count);
    int unsigned stop_at;
    int unsigned lim_x;
    int unsigned lim_y;
    int unsigned pick;
    bit          held;
    stop_at = word_cnt + count;
    lim_x   = axis_reach(sb.field_w(), sb.reg_sx);
    lim_y   = axis_reach(sb.field_h(), sb.reg_sy);
    held    = 1'b0;
    while (word_cnt < stop_at) begin
      pick = $urandom_range(99);
      if (!held && word_cnt >= stop_at - count / 2) begin
        hold_for_results();
        held = 1'b1;
      end else if (pick < 45) begin
        query_at($urandom_range(lim_x), $urandom_range(lim_y));
      end else if (pick < 80) begin
        send_word(make_word(REQ_LOAD, $urandom_range(sb.field_w() - 1),
                            $urandom_range(sb.field_h() - 1)));
      end else if (pick < 90) begin
        send_word(make_word(REQ_LOAD, $urandom_range(MAX_COORD), $urandom_range(MAX_COORD)));
      end else if (pick < 92) begin
        hold_for_results();
      end else begin
        query_at($urandom_range(MAX_COORD), $urandom_range(MAX_COORD));
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // sender idles on 20 percent of draws
    idle_pct = 20;
    set_field(8, 6, 24'h008000, 24'h005555, 1'b1);
    directed_words();
    random_words(PHASE_WORDS);
    set_field(1, 1, 24'h010000, 24'h000000, 1'b1);
    random_words(PHASE_WORDS);
    set_field(256, 256, 24'h003000, 24'h007000, 1'b0);
    random_words(PHASE_WORDS);

    // sender idles on 69 percent of draws
    idle_pct = 69;
    set_field(0, 0, 24'h012345, 24'hffffff, 1'b1);
    random_words(PHASE_WORDS);
    set_field(511, 300, 24'hffffff, 24'h000100, 1'b1);
    random_words(PHASE_WORDS);
    set_field(8, 6, 24'h004000, 24'h008000, 1'b1);
    random_words(PHASE_WORDS);

    // back to back
    idle_pct = 0;
    set_field(2, 2, 24'h000000, 24'h000000, 1'b0);
    random_words(PHASE_WORDS);
    repeat (2) begin
      set_field($urandom_range(1, 40), $urandom_range(1, 40), $urandom_range(24'h001000, 24'h030000),
                $urandom_range(24'h001000, 24'h030000), 1'($urandom));
      random_words(PHASE_WORDS);
    end

    hold_for_results();
    repeat (DRAIN_CYCLES + 4) @(posedge clk);
    if (sb.fail_cnt == 0) begin
      $display("bilinear_flow_field_upscaler test passed");
    end else begin
      $display("bilinear_flow_field_upscaler test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/bffu_pkg.sv
src/bffu_ram.sv
src/bffu_map.sv
src/bffu_blend.sv
src/bilinear_flow_field_upscaler.sv
sim/bilinear_flow_field_upscaler_tb.sv
